>>> rtl/smdu_pkg.sv
// Package for the shift / multiply / divide unit: widths, codes, control
// structs and the iteration-count and divide-check functions.
// No dependencies.
`default_nettype none
package smdu_pkg;

   localparam int WORD_W   = 16;
   localparam int ACTION_W = 2;
   localparam int FLAGS_W  = 4;
   localparam int CNT_W    = 6;

   localparam logic [CNT_W-1:0] MULDIV_STEPS = CNT_W'(WORD_W);
   localparam logic [CNT_W-1:0] RIGHT_MAX    = CNT_W'(2 * WORD_W);
   localparam logic [CNT_W-1:0] LEFT_MAX     = CNT_W'(2 * WORD_W + 1);
   localparam logic [7:0]       LEFT_LIMIT   = 8'd128;

   localparam logic [FLAGS_W-1:0] FLAGS_PRESET   = 4'b1001;
   localparam logic [FLAGS_W-1:0] FLAGS_DIV_ZERO = 4'b0011;
   localparam logic [FLAGS_W-1:0] FLAGS_DIV_OVF  = 4'b0010;

   typedef enum logic [ACTION_W-1:0] {
      ACT_ASH  = 2'd0,
      ACT_ASHC = 2'd1,
      ACT_MUL  = 2'd2,
      ACT_DIV  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      DIV_OK   = 2'd0,
      DIV_ZERO = 2'd1,
      DIV_OVF  = 2'd2
   } div_err_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_RUN  = 1'b1
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic finish;
   } ctrl_type;

   function automatic div_err_type div_check(input logic [WORD_W-1:0] high,
                                             input logic [WORD_W-1:0] divisor);
      div_err_type err;
      if (divisor == '0) begin
         err = DIV_ZERO;
      end else if (high >= divisor) begin
         err = DIV_OVF;
      end else begin
         err = DIV_OK;
      end
      return err;
   endfunction

   // Long shifts saturate: past these counts the words and carry stop changing.
   function automatic logic [CNT_W-1:0] iter_count(input logic [ACTION_W-1:0] action,
                                                   input logic [WORD_W-1:0]   high,
                                                   input logic [WORD_W-1:0]   operand);
      logic [7:0]       sc;
      logic [7:0]       k;
      logic [CNT_W-1:0] n;
      sc = operand[7:0];
      k  = 8'(~sc + 8'd1);
      n  = '0;
      case (action_type'(action)) inside
         ACT_ASH, ACT_ASHC: begin
            if (sc == 8'd0) begin
               n = '0;
            end else if (sc > LEFT_LIMIT) begin
               n = (k > 8'(RIGHT_MAX)) ? RIGHT_MAX : k[CNT_W-1:0];
            end else begin
               n = (sc > 8'(LEFT_MAX)) ? LEFT_MAX : sc[CNT_W-1:0];
            end
         end
         ACT_MUL: n = MULDIV_STEPS;
         default: n = (div_check(high, operand) == DIV_OK) ? MULDIV_STEPS : '0;
      endcase
      return n;
   endfunction

endpackage
`default_nettype wire

>>> rtl/smdu_if.sv
// Request and response channel interfaces for the shift / multiply / divide unit.
// Depends on smdu_pkg.
`default_nettype none
interface smdu_req_if;
   import smdu_pkg::*;
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [WORD_W-1:0]   reg_low;
   logic [WORD_W-1:0]   reg_high;
   logic [WORD_W-1:0]   operand;
   modport source (output valid, action, reg_low, reg_high, operand, input ready);
   modport sink   (input valid, action, reg_low, reg_high, operand, output ready);
endinterface

interface smdu_rsp_if;
   import smdu_pkg::*;
   logic               valid;
   logic               ready;
   logic [WORD_W-1:0]  new_low;
   logic [WORD_W-1:0]  new_high;
   logic [FLAGS_W-1:0] flags;
   modport source (output valid, new_low, new_high, flags, input ready);
   modport sink   (input valid, new_low, new_high, flags, output ready);
endinterface
`default_nettype wire

>>> rtl/shift_multiply_divide_unit.sv
// Shift / multiply / divide unit top level: sequencer, datapath, result register.
// Depends on smdu_pkg, smdu_if, smdu_seq, smdu_core.
//
// Executes arithmetic shift, combined 32-bit shift, unsigned 16x16 multiply
// and unsigned 32/16 divide on a register pair, giving new words and NZVC.
// req_chan carries one operation per beat; rsp_chan returns one result beat
// per request, in order. Both use valid/ready; a beat moves when both are high.
// One shared add/subtract/shift unit runs one bit per cycle under a counter.
// Multiply and divide iterate over all word bits; shifts iterate over min(count, 33)
// bits left or min(256 - count, 32) bits right; a zero shift count, divide by zero
// or overflow goes from accept to the result register with no iteration.
// The next request is taken in the same cycle a result is registered.
// If the receiver stalls, the finished result waits in the output register;
// the next item is still accepted and runs, and holds at its end until the
// output register empties. Reset (synchronous) empties the output register
// and returns the sequencer to idle.
`default_nettype none
module shift_multiply_divide_unit (
   input  logic      clock,
   input  logic      reset,
   smdu_req_if.sink  req_chan,
   smdu_rsp_if.source rsp_chan
);
   import smdu_pkg::*;

   ctrl_type           ctrl;
   logic               out_free;
   logic [WORD_W-1:0]  core_low, core_high;
   logic [FLAGS_W-1:0] core_flags;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]  rsp_low_ff, rsp_low_in;
   logic [WORD_W-1:0]  rsp_high_ff, rsp_high_in;
   logic [FLAGS_W-1:0] rsp_flags_ff, rsp_flags_in;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   smdu_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_chan.valid),
      .req_action   (req_chan.action),
      .req_reg_high (req_chan.reg_high),
      .req_operand  (req_chan.operand),
      .out_free     (out_free),
      .req_ready    (req_chan.ready),
      .ctrl         (ctrl)
   );

   smdu_core u_core (
      .clock        (clock),
      .ctrl         (ctrl),
      .req_action   (req_chan.action),
      .req_reg_low  (req_chan.reg_low),
      .req_reg_high (req_chan.reg_high),
      .req_operand  (req_chan.operand),
      .new_low      (core_low),
      .new_high     (core_high),
      .flags        (core_flags)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_low_ff   <= rsp_low_in;
      rsp_high_ff  <= rsp_high_in;
      rsp_flags_ff <= rsp_flags_in;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_low_in   = rsp_low_ff;
      rsp_high_in  = rsp_high_ff;
      rsp_flags_in = rsp_flags_ff;
      if (ctrl.finish) begin
         rsp_valid_in = 1'b1;
         rsp_low_in   = core_low;
         rsp_high_in  = core_high;
         rsp_flags_in = core_flags;
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.new_low  = rsp_low_ff;
   assign rsp_chan.new_high = rsp_high_ff;
   assign rsp_chan.flags    = rsp_flags_ff;

   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      ctrl.finish |-> out_free)
      else $error("result registered over an untaken beat");

   a_finish_valid: assert property (@(posedge clock) disable iff (reset)
      ctrl.finish |=> rsp_valid_ff)
      else $error("finished item did not raise response valid");

   a_busy_no_ready: assert property (@(posedge clock) disable iff (reset)
      ctrl.step |-> !req_chan.ready)
      else $error("request accepted while iterating");

   a_step_excl: assert property (@(posedge clock) disable iff (reset)
      ctrl.step |-> !ctrl.finish && !ctrl.load)
      else $error("step overlaps load or finish");

endmodule
`default_nettype wire

>>> rtl/smdu_seq.sv
// Sequencer: idle/run state machine and iteration counter that steps the
// shared arithmetic unit. Depends on smdu_pkg.
`default_nettype none
module smdu_seq (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic [smdu_pkg::ACTION_W-1:0]   req_action,
   input  logic [smdu_pkg::WORD_W-1:0]     req_reg_high,
   input  logic [smdu_pkg::WORD_W-1:0]     req_operand,
   input  logic                            out_free,
   output logic                            req_ready,
   output smdu_pkg::ctrl_type              ctrl
);
   import smdu_pkg::*;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      done        = (state_ff == ST_RUN) && (cnt_ff == '0);
      ctrl.finish = done && out_free;
      ctrl.step   = (state_ff == ST_RUN) && (cnt_ff != '0);
      req_ready   = (state_ff == ST_IDLE) || ctrl.finish;
      ctrl.load   = req_valid && req_ready;
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (ctrl.load) begin
               state_in = ST_RUN;
               cnt_in   = iter_count(req_action, req_reg_high, req_operand);
            end
         end
         ST_RUN: begin
            if (ctrl.step) begin
               cnt_in = cnt_ff - CNT_W'(1);
            end else if (ctrl.load) begin
               cnt_in = iter_count(req_action, req_reg_high, req_operand);
            end else if (ctrl.finish) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule
`default_nettype wire

>>> rtl/smdu_core.sv
// Datapath: word registers and one shared 17-bit add/subtract and shift unit,
// plus result and flag forming. Depends on smdu_pkg.
`default_nettype none
module smdu_core (
   input  logic                           clock,
   input  smdu_pkg::ctrl_type             ctrl,
   input  logic [smdu_pkg::ACTION_W-1:0]  req_action,
   input  logic [smdu_pkg::WORD_W-1:0]    req_reg_low,
   input  logic [smdu_pkg::WORD_W-1:0]    req_reg_high,
   input  logic [smdu_pkg::WORD_W-1:0]    req_operand,
   output logic [smdu_pkg::WORD_W-1:0]    new_low,
   output logic [smdu_pkg::WORD_W-1:0]    new_high,
   output logic [smdu_pkg::FLAGS_W-1:0]   flags
);
   import smdu_pkg::*;

   action_type        act_ff, act_in;
   logic [WORD_W-1:0] lo_ff, lo_in;
   logic [WORD_W-1:0] hi_ff, hi_in;
   logic [WORD_W-1:0] op_ff, op_in;
   logic              c_ff, c_in;
   logic              left_ff, left_in;
   logic              zero_ff, zero_in;
   div_err_type       err_ff, err_in;

   logic [WORD_W:0]   add_a, add_b;
   logic              add_sub;
   logic [WORD_W+1:0] add_sum;
   logic              pair_zero;
   action_type        ld_act;

   always_ff @(posedge clock) begin
      act_ff  <= act_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      op_ff   <= op_in;
      c_ff    <= c_in;
      left_ff <= left_in;
      zero_ff <= zero_in;
      err_ff  <= err_in;
   end

   // shared adder: multiply accumulates, divide trial-subtracts
   always_comb begin
      add_sub = (act_ff == ACT_DIV);
      add_a   = (act_ff == ACT_MUL) ? {1'b0, hi_ff} : {hi_ff, lo_ff[WORD_W-1]};
      add_b   = (act_ff == ACT_MUL && !lo_ff[0]) ? '0 : {1'b0, op_ff};
      add_sum = {1'b0, add_a} + {1'b0, add_sub ? ~add_b : add_b}
                + (WORD_W+2)'(add_sub);
   end

   always_comb begin
      ld_act  = action_type'(req_action);
      act_in  = act_ff;
      lo_in   = lo_ff;
      hi_in   = hi_ff;
      op_in   = op_ff;
      c_in    = c_ff;
      left_in = left_ff;
      zero_in = zero_ff;
      err_in  = err_ff;
      if (ctrl.load) begin
         act_in  = ld_act;
         lo_in   = req_reg_low;
         hi_in   = (ld_act == ACT_ASH) ? {WORD_W{req_reg_low[WORD_W-1]}} :
                   (ld_act == ACT_MUL) ? '0 : req_reg_high;
         op_in   = (ld_act == ACT_ASH) ? req_reg_high : req_operand;
         c_in    = 1'b1;
         left_in = !req_operand[7] || (req_operand[7:0] == LEFT_LIMIT);
         zero_in = (req_operand[7:0] == 8'd0);
         err_in  = div_check(req_reg_high, req_operand);
      end else if (ctrl.step) begin
         case (act_ff) inside
            ACT_ASH, ACT_ASHC: begin
               if (left_ff) begin
                  c_in  = (act_ff == ACT_ASH) ? lo_ff[WORD_W-1] : hi_ff[WORD_W-1];
                  hi_in = {hi_ff[WORD_W-2:0], lo_ff[WORD_W-1]};
                  lo_in = {lo_ff[WORD_W-2:0], 1'b0};
               end else begin
                  c_in  = lo_ff[0];
                  hi_in = {hi_ff[WORD_W-1], hi_ff[WORD_W-1:1]};
                  lo_in = {hi_ff[0], lo_ff[WORD_W-1:1]};
               end
            end
            ACT_MUL: begin
               hi_in = add_sum[WORD_W:1];
               lo_in = {add_sum[0], lo_ff[WORD_W-1:1]};
            end
            default: begin
               hi_in = add_sum[WORD_W+1] ? add_sum[WORD_W-1:0] : add_a[WORD_W-1:0];
               lo_in = {lo_ff[WORD_W-2:0], add_sum[WORD_W+1]};
            end
         endcase
      end
   end

   always_comb begin
      pair_zero = ({hi_ff, lo_ff} == '0);
      new_low   = lo_ff;
      new_high  = hi_ff;
      flags     = FLAGS_PRESET;
      case (act_ff)
         ACT_ASH: begin
            new_high = op_ff;
            if (!zero_ff) begin
               flags = {lo_ff[WORD_W-1], lo_ff == '0, lo_ff[WORD_W-1] ^ c_ff, c_ff};
            end
         end
         ACT_ASHC: begin
            if (!zero_ff) begin
               flags = {hi_ff[WORD_W-1], pair_zero, left_ff & pair_zero & c_ff, c_ff};
            end
         end
         ACT_MUL: flags = {hi_ff[WORD_W-1], pair_zero, 1'b0, 1'b1};
         default: begin
            case (err_ff)
               DIV_ZERO: flags = FLAGS_DIV_ZERO;
               DIV_OVF:  flags = FLAGS_DIV_OVF;
               default:  flags = {lo_ff[WORD_W-1], lo_ff == '0, 1'b0, 1'b1};
            endcase
         end
      endcase
   end

endmodule
`default_nettype wire
